// ----- src/blid_pkg.sv -----
// Shared constants, codes and the cell control struct for the bounded list.
package blid_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 8;
   localparam int ACTION_W     = 2;
   localparam int POS_W        = 4;
   localparam int STATUS_W     = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE     = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // Broadcast to every cell; flags are set only for operations that succeed.
   typedef struct packed {
      logic               push_front;
      logic               push_back;
      logic               remove;
      logic [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

// ----- src/blid_cell.sv -----
// One list cell: holds one entry and shifts with its neighbors.
module blid_cell
   import blid_pkg::*;
#(
   parameter int CNT_W      = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [CNT_W-1:0]   count,
   input  logic [CNT_W-1:0]   del_pos,
   input  logic [VALUE_W-1:0] left_value,
   input  logic [VALUE_W-1:0] right_value,
   output logic [VALUE_W-1:0] entry
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_INDEX);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;

   always_comb begin
      priority if (ctl.push_front) begin
         entry_in = left_value;
      end else if (ctl.push_back && (IDX == count)) begin
         entry_in = ctl.value;
      end else if (ctl.remove && (IDX >= del_pos)) begin
         entry_in = right_value;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- src/bounded_list_insert_delete_top.sv -----
// Top level of the bounded ordered byte list built from a row of shift cells.
//
//   channel   ports                                         handshake
//   request   req_action, req_value, req_position           start & !busy
//   result    rsp_status, rsp_removed_value, rsp_length,    rsp_valid strobe
//             rsp_front_value
//
// One request per cycle while busy is low; its result strobes in the cycle after acceptance.
// Every cell that moves shifts on the edge that accepts the request.
// Reset is synchronous; busy is high during reset and the cycle after it.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bounded_list_insert_delete_top
   import blid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]    req_position,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_removed_value,
   output logic [CNT_W-1:0]    rsp_length,
   output logic [VALUE_W-1:0]  rsp_front_value
);

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic                busy_ff;
   logic                valid_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  removed_ff, removed_in;

   logic                accept;
   logic                full;
   logic                pos_ok;
   logic [CNT_W-1:0]    pos_cnt;
   logic [VALUE_W-1:0]  sel_value;
   cell_ctl_type        ctl;
   logic [VALUE_W-1:0]  entry [CAPACITY];

   assign accept  = start & ~busy_ff;
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign pos_ok  = CMP_W'(req_position) < CMP_W'(count_ff);
   // only used when pos_ok, so the value fits
   assign pos_cnt = CNT_W'(req_position);

   always_comb begin
      sel_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CNT_W'(i) == pos_cnt) begin
            sel_value = entry[i];
         end
      end
   end

   always_comb begin
      ctl.push_front = 1'b0;
      ctl.push_back  = 1'b0;
      ctl.remove     = 1'b0;
      ctl.value      = req_value;
      count_in       = count_ff;
      status_in      = ST_DONE;
      removed_in     = '0;
      if (accept) begin
         unique case (req_action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.push_front = (req_action == ACT_PUSH_FRONT);
                  ctl.push_back  = (req_action == ACT_PUSH_BACK);
                  count_in       = count_ff + CNT_W'(1);
               end
            end
            ACT_DELETE: begin
               if (!pos_ok) begin
                  status_in = ST_RANGE;
               end else begin
                  ctl.remove = 1'b1;
                  removed_in = sel_value;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_v;
      logic [VALUE_W-1:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = req_value;
      end else begin : g_mid
         assign left_v = entry[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_v = entry[g];
      end else begin : g_inner
         assign right_v = entry[g+1];
      end
      blid_cell #(
         .CNT_W      (CNT_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .del_pos     (pos_cnt),
         .left_value  (left_v),
         .right_value (right_v),
         .entry       (entry[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= accept;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

   assign busy              = busy_ff;
   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_length        = count_ff;
   assign rsp_front_value   = (count_ff != '0) ? entry[0] : '0;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the bounded ordered byte list: directed corner cases, then random.
`timescale 1ns / 100ps

module tb;
   import blid_pkg::*;

   localparam int LIST_CAP       = CAPACITY_DEF;
   localparam int LEN_W          = $clog2(LIST_CAP + 1);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_LIMIT    = 200;
   localparam int TAIL_CYCLES    = 4;
   localparam int PHASE_ITEMS    = 600;
   // Unused action code; the block must leave the list alone.
   localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  removed;
      logic [LEN_W-1:0]    length;
      logic [VALUE_W-1:0]  front;
   } list_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action   = '0;
   logic [VALUE_W-1:0]  req_value    = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_removed_value;
   logic [LEN_W-1:0]    rsp_length;
   logic [VALUE_W-1:0]  rsp_front_value;

   // Shadow copy of the list, updated when a request is accepted.
   logic [VALUE_W-1:0] list_model [LIST_CAP];
   int                 model_count = 0;
   list_result_type    expected_results [$];

   int fails       = 0;
   int idle_cycles = 0;
   int n_checked   = 0;
   int n_push      = 0;
   int n_delete    = 0;
   int n_full      = 0;
   int n_range     = 0;

   bounded_list_insert_delete_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_length        (rsp_length),
      .rsp_front_value   (rsp_front_value)
   );

   always #4 clock = ~clock;

   function automatic list_result_type apply_list_action(input logic [ACTION_W-1:0] act,
                                                         input logic [VALUE_W-1:0] val,
                                                         input logic [POS_W-1:0] pos);
      list_result_type res;
      int              i;
      res = '0;
      if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
         if (model_count >= LIST_CAP) begin
            res.status = ST_FULL;
            n_full++;
         end else if (act == ACT_PUSH_FRONT) begin
            for (i = model_count; i > 0; i--) list_model[i] = list_model[i-1];
            list_model[0] = val;
            model_count++;
            n_push++;
         end else begin
            list_model[model_count] = val;
            model_count++;
            n_push++;
         end
      end else if (act == ACT_DELETE) begin
         if (int'(pos) >= model_count) begin
            res.status = ST_RANGE;
            n_range++;
         end else begin
            res.removed = list_model[pos];
            for (i = int'(pos); i + 1 < model_count; i++) list_model[i] = list_model[i+1];
            model_count--;
            n_delete++;
         end
      end
      res.length = LEN_W'(model_count);
      res.front  = (model_count > 0) ? list_model[0] : '0;
      return res;
   endfunction

   // Drive one request at the falling edge and hold it until the block takes it.
   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                               input logic [POS_W-1:0] pos);
      @(negedge clock);
      start        = 1'b1;
      req_action   = act;
      req_value    = val;
      req_position = pos;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(apply_list_action(act, val, pos));
   endtask

   // Each cycle idles with the given percentage, so that share of cycles carries no request.
   task automatic idle_gap(input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic report_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      list_result_type exp_r;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d length %0d",
                     $time, rsp_status, rsp_length);
            fails++;
         end else begin
            exp_r = expected_results.pop_front();
            report_field("status", exp_r.status, rsp_status);
            report_field("removed_value", exp_r.removed, rsp_removed_value);
            report_field("length", exp_r.length, rsp_length);
            report_field("front_value", exp_r.front, rsp_front_value);
            n_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, expected_results.size());
         $display("** bounded_list_insert_delete_top: FAILED **");
         $finish;
      end
   end

   task automatic test_empty_list;
      send_request(ACT_DELETE, 8'h00, 4'd0);
      send_request(ACT_DELETE, 8'hFF, 4'd15);
      send_request(ACT_IGNORED, 8'h5A, 4'd9);
   endtask

   // Removing the only entry must leave length 0 and front 0.
   task automatic test_single_entry;
      send_request(ACT_PUSH_BACK, 8'h00, 4'd0);
      send_request(ACT_DELETE, 8'h00, 4'd0);
      send_request(ACT_PUSH_FRONT, 8'hFF, 4'd15);
      send_request(ACT_DELETE, 8'h00, 4'd1);
      send_request(ACT_DELETE, 8'h00, 4'd0);
   endtask

   task automatic test_fill_and_overflow;
      int         i;
      logic [3:0] k;
      for (i = 0; i < LIST_CAP; i++) begin
         k = i[3:0];
         send_request((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, {k, ~k}, ~k);
      end
      send_request(ACT_PUSH_FRONT, 8'h00, 4'd0);
      send_request(ACT_PUSH_BACK, 8'hFF, 4'd15);
      send_request(ACT_IGNORED, 8'hA5, 4'd3);
   endtask

   task automatic test_delete_positions;
      send_request(ACT_DELETE, 8'h00, 4'd15);
      send_request(ACT_DELETE, 8'h00, 4'd0);
      send_request(ACT_DELETE, 8'h00, 4'd7);
      send_request(ACT_DELETE, 8'h00, 4'd13);
      send_request(ACT_DELETE, 8'h00, 4'd12);
   endtask

   // Runs of push-heavy and delete-heavy traffic so the list swings between empty and full.
   task automatic test_random_traffic(input int n_items, input int idle_pct);
      int                  sent;
      int                  push_bias;
      logic [ACTION_W-1:0] act;
      logic [POS_W-1:0]    pos;
      sent      = 0;
      push_bias = 50;
      while (sent < n_items) begin
         if (sent % 40 == 0) push_bias = $urandom_range(20, 80);
         if ($urandom_range(0, 99) < 3) act = ACT_IGNORED;
         else if ($urandom_range(0, 99) < push_bias)
            act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
         else act = ACT_DELETE;
         if (model_count > 0 && $urandom_range(0, 9) < 8)
            pos = POS_W'($urandom_range(0, model_count - 1));
         else pos = POS_W'($urandom_range(0, 15));
         idle_gap(idle_pct);
         send_request(act, VALUE_W'($urandom_range(0, 255)), pos);
         if (act != ACT_IGNORED) sent++;
      end
   endtask

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_single_entry();
      test_fill_and_overflow();
      test_delete_positions();
      test_random_traffic(PHASE_ITEMS, 37);
      test_random_traffic(PHASE_ITEMS, 80);
      test_random_traffic(PHASE_ITEMS, 0);

      @(negedge clock);
      start = 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_results.size());
         fails++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d pushes, %0d deletes accepted", n_checked, n_push,
               n_delete);
      $display("Rejections seen: %0d pushes into a full list, %0d deletes out of range",
               n_full, n_range);
      if (fails == 0) begin
         $display("** bounded_list_insert_delete_top: PASSED **");
      end else begin
         $display("** bounded_list_insert_delete_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/blid_pkg.sv
src/blid_cell.sv
src/bounded_list_insert_delete_top.sv
test/tb.sv
